/* src/cfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFL step package
// Widths, register indexes and the shared compare/subtract result type.
// ----------------------------------------------------------------------------
package cfl_pkg;

   localparam int unsigned DataW = 32;
   localparam int unsigned UnitW = 64;
   localparam int unsigned CsrIdxW = 2;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CSR_CFL_FACTOR = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_STEP = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SMALL_THRESHOLD = 2'd2;

   // Result of the shared compare/subtract unit.
   typedef struct packed {
      logic ge;
      logic [UnitW-1:0] diff;
   } cmp_res_type;

endpackage

/* src/cfl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFL step channels
// Particle request channel and step response channel.
// ----------------------------------------------------------------------------
interface cfl_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [31:0] acc_z;
   logic [4:0] level;
   logic last_item;

   modport source (output valid, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, level,
      last_item, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, level,
      last_item, output ready);
endinterface

interface cfl_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] min_step;

   modport source (output valid, min_step, input ready);
   modport sink (input valid, min_step, output ready);
endinterface

/* src/cfl_cmpsub.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFL shared compare/subtract unit
// One wide compare and subtract, used by both the square root and divider.
// ----------------------------------------------------------------------------
module cfl_cmpsub (
   input  logic [cfl_pkg::UnitW-1:0] op_a,
   input  logic [cfl_pkg::UnitW-1:0] op_b,
   output cfl_pkg::cmp_res_type      res
);
   import cfl_pkg::*;

   // The difference is only used when a is at or above b.
   always_comb begin
      res.ge = (op_a >= op_b);
      res.diff = op_a - op_b;
   end

endmodule

/* src/cfl_timestep_min_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CFL time step minimum reduce
// Per particle, forms a step candidate per axis above threshold; keeps the minimum.
//
//   channel | dir | payload
//   req_ch  | in  | vel_x/y/z, acc_x/y/z, level, last_item
//   rsp_ch  | out | min_step (only after a last item)
//   csr_*   | in  | cfl_factor, max_step, small_threshold
//
// A particle is accepted in the idle state; then, per axis with acceleration
// above the small threshold: magnitudes, two multiplies, sum, a 32-bit square
// root, divide setup, a 48-bit divide and the fold into the minimum; with
// velocity only above it: magnitudes, divide, fold; with neither, a skip. A
// last item then posts its result. Root and divide share one compare/subtract
// unit. Reset is synchronous; running minimum resets to all ones. The request
// side is not ready while a particle is in work or a result is stuck.
// ----------------------------------------------------------------------------
module cfl_timestep_min_reduce (
   input  logic                          clock,
   input  logic                          reset,
   cfl_req_if.sink                       req_ch,
   cfl_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [cfl_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [cfl_pkg::DataW-1:0]     csr_wdata
);
   import cfl_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MAG  = 4'd1;
   localparam logic [3:0] ST_MUL1 = 4'd2;
   localparam logic [3:0] ST_MUL2 = 4'd3;
   localparam logic [3:0] ST_SUM  = 4'd4;
   localparam logic [3:0] ST_SQRT = 4'd5;
   localparam logic [3:0] ST_DIVP = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_UPD  = 4'd8;
   localparam logic [3:0] ST_NEXT = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]  state_ff;
   logic [15:0] cfl_ff;
   logic [31:0] max_ff;
   logic [15:0] thr_ff;
   logic [31:0] run_min_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic [31:0] vel_ff [3];
   logic [31:0] acc_ff [3];
   logic [4:0]  lvl_ff;
   logic        last_ff;
   logic [1:0]  axis_ff;

   logic [31:0] vm_ff;
   logic [31:0] am_ff;
   logic [63:0] prod_ff;
   logic [63:0] sq_ff;
   logic [63:0] rad_ff;
   logic [63:0] rem_ff;
   logic [31:0] root_ff;
   logic [47:0] num_ff;
   logic [62:0] den_ff;
   logic [47:0] quo_ff;
   logic [5:0]  cnt_ff;

   logic [31:0] vel_cur;
   logic [31:0] acc_cur;
   logic [31:0] vm_in;
   logic [31:0] am_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] mul_p;
   logic [63:0] op_a;
   logic [63:0] op_b;
   cmp_res_type cmp;
   logic [31:0] cand;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.min_step = rsp_data_ff;

   // Magnitudes of the current axis; the most negative value maps to 2^31.
   always_comb begin
      vel_cur = vel_ff[axis_ff];
      acc_cur = acc_ff[axis_ff];
      vm_in = vel_cur[31] ? (~vel_cur + 32'd1) : vel_cur;
      am_in = acc_cur[31] ? (~acc_cur + 32'd1) : acc_cur;
   end

   // Single multiplier: v*v first, then a*cfl.
   always_comb begin
      mul_x = (state_ff == ST_MUL1) ? vm_ff : am_ff;
      mul_y = (state_ff == ST_MUL1) ? vm_ff : {16'd0, cfl_ff};
      mul_p = {32'd0, mul_x} * {32'd0, mul_y};
   end

   // Operands of the shared unit: square root step or divide step.
   always_comb begin
      if (state_ff == ST_SQRT) begin
         op_a = {rem_ff[61:0], rad_ff[63:62]};
         op_b = {30'd0, root_ff, 2'b01};
      end else begin
         op_a = {rem_ff[62:0], num_ff[47]};
         op_b = {1'b0, den_ff};
      end
   end

   cfl_cmpsub u_cmpsub (
      .op_a (op_a),
      .op_b (op_b),
      .res  (cmp)
   );

   // Saturated candidate.
   assign cand = (quo_ff[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_ff[31:0];

   // Sequencer and datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfl_ff <= 16'd32768;
         max_ff <= 32'hFFFF_FFFF;
         thr_ff <= 16'd0;
         run_min_ff <= 32'hFFFF_FFFF;
         rsp_valid_ff <= 1'b0;
         axis_ff <= 2'd0;
         cnt_ff <= 6'd0;
      end else begin
         // The done state reloads the output register itself.
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  vel_ff[0] <= req_ch.vel_x;
                  vel_ff[1] <= req_ch.vel_y;
                  vel_ff[2] <= req_ch.vel_z;
                  acc_ff[0] <= req_ch.acc_x;
                  acc_ff[1] <= req_ch.acc_y;
                  acc_ff[2] <= req_ch.acc_z;
                  lvl_ff <= req_ch.level;
                  last_ff <= req_ch.last_item;
                  axis_ff <= 2'd0;
                  state_ff <= ST_MAG;
               end
            end
            ST_MAG: begin
               vm_ff <= vm_in;
               am_ff <= am_in;
               rem_ff <= 64'd0;
               root_ff <= 32'd0;
               quo_ff <= 48'd0;
               cnt_ff <= 6'd0;
               if (am_in > {16'd0, thr_ff}) begin
                  state_ff <= ST_MUL1;
               end else if (vm_in > {16'd0, thr_ff}) begin
                  num_ff <= {16'd0, cfl_ff, 16'd0};
                  den_ff <= {31'd0, vm_in} << lvl_ff;
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_MUL1: begin
               prod_ff <= mul_p;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               sq_ff <= prod_ff;
               prod_ff <= mul_p;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rad_ff <= sq_ff + ({15'd0, prod_ff[47:0], 1'b0} >> lvl_ff);
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               // Two radicand bits per step, one root bit out.
               rad_ff <= {rad_ff[61:0], 2'b00};
               if (cmp.ge) begin
                  rem_ff <= cmp.diff;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= op_a;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= ST_DIVP;
               end
            end
            ST_DIVP: begin
               num_ff <= {root_ff - vm_ff, 16'd0};
               den_ff <= {31'd0, am_ff};
               rem_ff <= 64'd0;
               cnt_ff <= 6'd0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // Restoring divide, one quotient bit per step.
               num_ff <= {num_ff[46:0], 1'b0};
               if (cmp.ge) begin
                  rem_ff <= cmp.diff;
                  quo_ff <= {quo_ff[46:0], 1'b1};
               end else begin
                  rem_ff <= op_a;
                  quo_ff <= {quo_ff[46:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) begin
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               if (cand < run_min_ff) begin
                  run_min_ff <= cand;
               end
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= last_ff ? ST_DONE : ST_IDLE;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
                  state_ff <= ST_MAG;
               end
            end
            ST_DONE: begin
               // Wait for the output register to free up.
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= run_min_ff;
                  run_min_ff <= max_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // Register writes; a new maximum restarts the reduction.
         if (csr_we) begin
            unique case (csr_index)
               CSR_CFL_FACTOR: cfl_ff <= csr_wdata[15:0];
               CSR_MAX_STEP: begin
                  max_ff <= csr_wdata;
                  run_min_ff <= csr_wdata;
               end
               CSR_SMALL_THRESHOLD: thr_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   // An accepted word leaves the request side busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted twice in a row");

   // A new result only appears from the final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

   // The running minimum never exceeds the bound.
   a_min_bounded: assert property (@(posedge clock) disable iff (reset)
      run_min_ff <= max_ff)
      else $error("running minimum above max step");

   // The step counter stays within the longest sweep.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 6'd48)
      else $error("step counter out of range");

endmodule
